[hdl/virtqueue_rx_tx_ring_engine_defines.svh]
// ----------------------------------------------------------------------------
// virtqueue_rx_tx_ring_engine_defines.svh
// Assertion macros used by the ring engine core (vqring_core).
// ----------------------------------------------------------------------------
`ifndef VIRTQUEUE_RX_TX_RING_ENGINE_DEFINES_SVH
`define VIRTQUEUE_RX_TX_RING_ENGINE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define VQRING_ASSERT_IMPLY(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("vqring: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define VQRING_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("vqring: next-cycle check failed");

`endif

[hdl/vqring_pkg.sv]
// ----------------------------------------------------------------------------
// vqring_pkg
// Types and constants of the virtqueue RX/TX ring engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vqring_pkg;

  localparam int HDR_BYTES = 10;
  localparam int TX_LIMIT  = 2048;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam logic [2:0] REG_LINK_UP = 3'd0;
  localparam logic [2:0] REG_RX_SIZE = 3'd1;
  localparam logic [2:0] REG_TX_SIZE = 3'd2;
  localparam logic [2:0] REG_RX_BASE = 3'd3;
  localparam logic [2:0] REG_TX_BASE = 3'd4;

  typedef enum logic [1:0] {
    REQ_POST = 2'd0,
    REQ_POLL = 2'd1,
    REQ_SEND = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_FRAME     = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RECYCLED  = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_DOWN      = 3'd4,
    ST_TX_OK     = 3'd5,
    ST_TX_REJECT = 3'd6,
    ST_POSTED    = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POST_MOD,
    S_POLL_MOD,
    S_POLL_CHK,
    S_RCY_MOD,
    S_TX_MOD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        link_up;
    logic [8:0]  rx_queue_size;
    logic [8:0]  tx_queue_size;
    logic [31:0] rx_buf_base;
    logic [31:0] tx_buf_base;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [8:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [8:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload_len;
    logic [15:0] xfer_len;
    logic [31:0] data_addr;
    logic [7:0]  ring_pos;
    logic [7:0]  ring_head;
    logic [15:0] avail_idx;
    logic        notify;
    logic        queue_sel;
  } result_t;

endpackage

`default_nettype wire

[hdl/vqring_req_if.sv]
// ----------------------------------------------------------------------------
// vqring_req_if
// Request channel: valid/ready handshake with one request beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vqring_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] used_id;
  logic [31:0] used_len;
  logic [15:0] length;

  modport source (output valid, req_type, used_id, used_len, length, input ready);
  modport sink   (input valid, req_type, used_id, used_len, length, output ready);
endinterface

`default_nettype wire

[hdl/vqring_rsp_if.sv]
// ----------------------------------------------------------------------------
// vqring_rsp_if
// Result channel: valid/ready handshake with one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vqring_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] payload_len;
  logic [15:0] xfer_len;
  logic [31:0] data_addr;
  logic [7:0]  ring_pos;
  logic [7:0]  ring_head;
  logic [15:0] avail_idx;
  logic        notify;
  logic        queue_sel;

  modport source (output valid, status, payload_len, xfer_len, data_addr, ring_pos,
                  ring_head, avail_idx, notify, queue_sel, input ready);
  modport sink   (input valid, status, payload_len, xfer_len, data_addr, ring_pos,
                  ring_head, avail_idx, notify, queue_sel, output ready);
endinterface

`default_nettype wire

[hdl/virtqueue_rx_tx_ring_engine.sv]
// ----------------------------------------------------------------------------
// virtqueue_rx_tx_ring_engine
// Driver-side split virtqueue bookkeeping for a network device.
// Channels: req (sink) takes one request beat: device completion post,
// RX poll or TX send; rsp (source) gives one result beat per request, and
// none for the unused request code. Registers are written over APB.
// One request is in flight at a time; ready is high only when idle.
// Link down, empty ring and rejected send go straight to the result; a post
// or an accepted send first runs one remainder pass, a poll that drops its
// entry one pass and the used-ring read, a poll that recycles two passes and
// the read. The next request is taken in the cycle after the result loads.
// The shared remainder unit reduces a ring count modulo the queue size one
// bit per cycle (one pass for a post or send, two for a recycling poll).
// Reset clears the ring counters and the registers; the used ring itself
// holds no reset value and an entry reads back only after it is posted.
// A result waits in the output register while rsp is stalled; the next
// request is still taken and runs until its own result is ready to load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module virtqueue_rx_tx_ring_engine #(
  parameter int QUEUE_DEPTH  = 256,
  parameter int BUFFER_BYTES = 2048
) (
  input  wire                              clk,
  input  wire                              rst,
  vqring_req_if.sink                       req,
  vqring_rsp_if.source                     rsp,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [vqring_pkg::PADDR_W-1:0]    paddr,
  input  wire [vqring_pkg::PDATA_W-1:0]    pwdata,
  output logic [vqring_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready
);
  import vqring_pkg::*;

  cfg_t cfg;

  vqring_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vqring_core #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

[hdl/vqring_mod.sv]
// ----------------------------------------------------------------------------
// vqring_mod
// Radix-2 restoring remainder unit: 16-bit count modulo 9-bit queue size,
// one dividend bit per cycle. A zero divisor yields a zero remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vqring_mod (
  input  wire                 clk,
  input  wire                 rst,
  input  vqring_pkg::mod_req_t mreq,
  output vqring_pkg::mod_rsp_t mrsp
);
  import vqring_pkg::*;

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [15:0] dq;
  logic [8:0]  dv;
  logic [8:0]  r;
  logic [9:0]  trial;
  logic        fits;

  assign trial = {r, dq[15]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (mreq.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'hF) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.start) begin
      dq <= mreq.dividend;
      dv <= mreq.divisor;
      r  <= '0;
    end else if (busy) begin
      dq <= {dq[14:0], 1'b0};
      r  <= fits ? 9'(trial - {1'b0, dv}) : trial[8:0];
    end
  end

  assign mrsp.done = done;
  assign mrsp.rem  = (dv == '0) ? '0 : r;

endmodule

`default_nettype wire

[hdl/vqring_cfg.sv]
// ----------------------------------------------------------------------------
// vqring_cfg
// APB register file: link state, queue sizes and buffer base addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vqring_cfg (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [vqring_pkg::PADDR_W-1:0]    paddr,
  input  wire [vqring_pkg::PDATA_W-1:0]    pwdata,
  output logic [vqring_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready,
  output vqring_pkg::cfg_t                 cfg
);
  import vqring_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_up       <= 1'b0;
      cfg.rx_queue_size <= 9'd256;
      cfg.tx_queue_size <= 9'd256;
      cfg.rx_buf_base   <= '0;
      cfg.tx_buf_base   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_LINK_UP: cfg.link_up       <= pwdata[0];
        REG_RX_SIZE: cfg.rx_queue_size <= pwdata[8:0];
        REG_TX_SIZE: cfg.tx_queue_size <= pwdata[8:0];
        REG_RX_BASE: cfg.rx_buf_base   <= pwdata;
        REG_TX_BASE: cfg.tx_buf_base   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LINK_UP: prdata = {31'b0, cfg.link_up};
      REG_RX_SIZE: prdata = {23'b0, cfg.rx_queue_size};
      REG_TX_SIZE: prdata = {23'b0, cfg.tx_queue_size};
      REG_RX_BASE: prdata = cfg.rx_buf_base;
      REG_TX_BASE: prdata = cfg.tx_buf_base;
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/vqring_core.sv]
// ----------------------------------------------------------------------------
// vqring_core
// Request sequencer around the RX used-ring memory, the ring counters, the
// shared remainder unit and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "virtqueue_rx_tx_ring_engine_defines.svh"

module vqring_core #(
  parameter int QUEUE_DEPTH  = 256,
  parameter int BUFFER_BYTES = 2048
) (
  input  wire              clk,
  input  wire              rst,
  input  vqring_pkg::cfg_t cfg,
  vqring_req_if.sink       req,
  vqring_rsp_if.source     rsp
);
  import vqring_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  state_t      state, state_next;
  mod_req_t    mreq;
  mod_rsp_t    mrsp;

  logic [15:0] dev_cnt, cons_cnt, rcy_cnt, tx_cnt;
  logic        dev_inc, cons_inc, rcy_inc, tx_inc;

  logic [15:0] item_id;
  logic [31:0] item_len;
  logic [15:0] item_length;
  logic        take;

  logic [47:0] mem [QUEUE_DEPTH];
  logic [47:0] rd_data;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_addr;

  result_t     res, res_next;
  result_t     out;
  logic        out_valid;
  logic        out_load;

  logic [31:0] prod, prod_next;
  logic [8:0]  eff_size;
  logic [15:0] rcy_old;

  // Entry fields and checks for the poll
  logic [15:0] e_id;
  logic [31:0] e_len;
  logic [7:0]  e_slot;
  logic [31:0] e_frame;
  logic        id_ok, len_ok, slot_ok;

  vqring_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .mreq (mreq),
    .mrsp (mrsp)
  );

  always_comb begin
    if ({23'b0, cfg.rx_queue_size} > 32'(QUEUE_DEPTH)) begin
      eff_size = 9'(QUEUE_DEPTH);
    end else begin
      eff_size = cfg.rx_queue_size;
    end
  end

  assign rcy_old  = 16'(eff_size[8:1]) + rcy_cnt;
  assign mem_addr = AW'(mrsp.rem);

  assign e_id    = rd_data[47:32];
  assign e_len   = rd_data[31:0];
  assign e_slot  = e_id[8:1];
  assign e_frame = e_len - 32'(HDR_BYTES);
  assign id_ok   = (e_id < {7'b0, eff_size}) && !e_id[0];
  assign len_ok  = e_len > 32'(HDR_BYTES);
  assign slot_ok = {1'b0, e_slot} < {1'b0, eff_size[8:1]};

  assign req.ready = (state == S_IDLE);
  assign take      = req.valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    prod_next  = prod;
    mreq       = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    dev_inc    = 1'b0;
    cons_inc   = 1'b0;
    rcy_inc    = 1'b0;
    tx_inc     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_next = '0;
          unique case (req_t'(req.req_type))
            REQ_NONE: state_next = S_IDLE;
            REQ_POST: begin
              if (!cfg.link_up) begin
                res_next.status = ST_DOWN;
                state_next      = S_EMIT;
              end else begin
                mreq       = '{start: 1'b1, dividend: dev_cnt, divisor: eff_size};
                state_next = S_POST_MOD;
              end
            end
            REQ_POLL: begin
              if (!cfg.link_up) begin
                res_next.status = ST_DOWN;
                state_next      = S_EMIT;
              end else if (cons_cnt == dev_cnt) begin
                res_next.status = ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                mreq       = '{start: 1'b1, dividend: cons_cnt, divisor: eff_size};
                state_next = S_POLL_MOD;
              end
            end
            REQ_SEND: begin
              if (!cfg.link_up) begin
                res_next.status = ST_DOWN;
                state_next      = S_EMIT;
              end else if (req.length == '0 ||
                           ({1'b0, req.length} + 17'(HDR_BYTES)) > 17'(TX_LIMIT)) begin
                res_next.status = ST_TX_REJECT;
                state_next      = S_EMIT;
              end else begin
                mreq       = '{start: 1'b1, dividend: tx_cnt,
                               divisor: cfg.tx_queue_size};
                state_next = S_TX_MOD;
              end
            end
          endcase
        end
      end
      S_POST_MOD: begin
        if (mrsp.done) begin
          mem_we          = 1'b1;
          dev_inc         = 1'b1;
          res_next.status = ST_POSTED;
          state_next      = S_EMIT;
        end
      end
      S_POLL_MOD: begin
        if (mrsp.done) begin
          mem_re     = 1'b1;
          cons_inc   = 1'b1;
          state_next = S_POLL_CHK;
        end
      end
      S_POLL_CHK: begin
        res_next.ring_head = e_id[7:0];
        priority if (!id_ok) begin
          res_next.status    = ST_DROPPED;
          res_next.ring_head = '0;
          state_next         = S_EMIT;
        end else if (!len_ok) begin
          res_next.status = ST_RECYCLED;
          mreq            = '{start: 1'b1, dividend: rcy_old, divisor: eff_size};
          state_next      = S_RCY_MOD;
        end else if (!slot_ok) begin
          res_next.status    = ST_DROPPED;
          res_next.ring_head = '0;
          state_next         = S_EMIT;
        end else begin
          res_next.status      = ST_FRAME;
          res_next.payload_len = e_frame;
          res_next.xfer_len    = (e_frame < {16'b0, item_length}) ? e_frame[15:0]
                                                                   : item_length;
          prod_next            = 32'(e_slot) * 32'(BUFFER_BYTES);
          mreq                 = '{start: 1'b1, dividend: rcy_old, divisor: eff_size};
          state_next           = S_RCY_MOD;
        end
      end
      S_RCY_MOD: begin
        if (mrsp.done) begin
          rcy_inc            = 1'b1;
          res_next.ring_pos  = mrsp.rem[7:0];
          res_next.avail_idx = rcy_old + 16'd1;
          res_next.notify    = 1'b1;
          res_next.queue_sel = 1'b0;
          if (res.status == ST_FRAME) begin
            res_next.data_addr = cfg.rx_buf_base + prod + 32'(HDR_BYTES);
          end
          state_next = S_EMIT;
        end
      end
      S_TX_MOD: begin
        if (mrsp.done) begin
          tx_inc             = 1'b1;
          res_next.status    = ST_TX_OK;
          res_next.xfer_len  = item_length;
          res_next.data_addr = cfg.tx_buf_base + 32'(HDR_BYTES);
          res_next.ring_pos  = mrsp.rem[7:0];
          res_next.ring_head = '0;
          res_next.avail_idx = tx_cnt + 16'd1;
          res_next.notify    = 1'b1;
          res_next.queue_sel = 1'b1;
          state_next         = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the result register is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_cnt  <= '0;
      cons_cnt <= '0;
      rcy_cnt  <= '0;
      tx_cnt   <= '0;
    end else begin
      if (dev_inc)  dev_cnt  <= dev_cnt + 16'd1;
      if (cons_inc) cons_cnt <= cons_cnt + 16'd1;
      if (rcy_inc)  rcy_cnt  <= rcy_cnt + 16'd1;
      if (tx_inc)   tx_cnt   <= tx_cnt + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    res  <= res_next;
    prod <= prod_next;
    if (take) begin
      item_id     <= req.used_id;
      item_len    <= req.used_len;
      item_length <= req.length;
    end
  end

  // Used ring: one write port for posts, registered read for polls. A post
  // always finishes before the next request is taken, so no forwarding.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {item_id, item_len};
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out.status;
  assign rsp.payload_len = out.payload_len;
  assign rsp.xfer_len    = out.xfer_len;
  assign rsp.data_addr   = out.data_addr;
  assign rsp.ring_pos    = out.ring_pos;
  assign rsp.ring_head   = out.ring_head;
  assign rsp.avail_idx   = out.avail_idx;
  assign rsp.notify      = out.notify;
  assign rsp.queue_sel   = out.queue_sel;

  `VQRING_ASSERT_IMPLY(a_mod_done_in_wait, clk, rst, mrsp.done,
    (state == S_POST_MOD || state == S_POLL_MOD || state == S_RCY_MOD || state == S_TX_MOD))
  `VQRING_ASSERT_IMPLY(a_poll_ring_nonempty, clk, rst, (state == S_POLL_MOD),
    (cons_cnt != dev_cnt))
  `VQRING_ASSERT_NEXT(a_emit_loads_result, clk, rst, (state == S_EMIT && out_load),
    (state == S_IDLE && out_valid))

endmodule

`default_nettype wire

[dv/vqring_ring_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqring_ring_checker
// Watches the request, result and APB channels of the ring engine. Keeps its
// own copy of the registers, the used ring and the ring counters, works out
// the result of every accepted request beat and compares each result beat
// with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------

module vqring_ring_checker #(
  parameter int QUEUE_DEPTH  = 256,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  vqring_req_if                          req_mon,
  vqring_rsp_if                          rsp_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vqring_pkg::PADDR_W-1:0] paddr,
  input  logic [vqring_pkg::PDATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             pending,
  output int                             errors
);
  import vqring_pkg::*;

  logic        cfg_link;
  logic [8:0]  cfg_rx_size;
  logic [8:0]  cfg_tx_size;
  logic [31:0] cfg_rx_base;
  logic [31:0] cfg_tx_base;

  logic [15:0] used_ids  [QUEUE_DEPTH];
  logic [31:0] used_lens [QUEUE_DEPTH];
  logic [15:0] posted_cnt;
  logic [15:0] taken_cnt;
  logic [15:0] rcy_cnt;
  logic [15:0] tx_cnt;

  result_t due_results [$];
  result_t due_head;
  result_t fresh;
  int      mism = 0;

  function automatic int unsigned ring_slot(input logic [15:0] count, input int unsigned size);
    return (size == 0) ? 0 : count % size;
  endfunction

  // Update the shadow rings for one request; returns 0 when no result beat follows.
  function automatic bit compute_ring_result(input req_t kind, input logic [15:0] uid,
                                             input logic [31:0] ulen, input logic [15:0] blen,
                                             output result_t res);
    int unsigned esz;
    int unsigned p;
    int unsigned hid;
    int unsigned hlen;
    int unsigned slot;
    int unsigned frame;
    logic [15:0] old;
    res = '0;
    esz = (int'(cfg_rx_size) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cfg_rx_size);
    if (kind == REQ_NONE) return 1'b0;
    if (!cfg_link) begin
      res.status = ST_DOWN;
      return 1'b1;
    end
    case (kind)
      REQ_POST: begin
        p = ring_slot(posted_cnt, esz);
        used_ids[p]  = uid;
        used_lens[p] = ulen;
        posted_cnt   = posted_cnt + 16'd1;
        res.status   = ST_POSTED;
      end
      REQ_POLL: begin
        if (taken_cnt == posted_cnt) begin
          res.status = ST_EMPTY;
        end else begin
          p         = ring_slot(taken_cnt, esz);
          hid       = used_ids[p];
          hlen      = used_lens[p];
          taken_cnt = taken_cnt + 16'd1;
          slot      = hid / 2;
          if (hid >= esz || hid % 2 != 0) begin
            res.status = ST_DROPPED;
          end else if (hlen <= HDR_BYTES) begin
            res.status = ST_RECYCLED;
          end else if (slot >= esz / 2) begin
            // odd queue size: the top even id has no buffer slot
            res.status = ST_DROPPED;
          end else begin
            frame           = hlen - HDR_BYTES;
            res.status      = ST_FRAME;
            res.payload_len = frame;
            res.xfer_len    = (frame < blen) ? frame[15:0] : blen;
            res.data_addr   = 32'(cfg_rx_base + slot * BUFFER_BYTES + HDR_BYTES);
          end
          if (res.status == ST_RECYCLED || res.status == ST_FRAME) begin
            // avail index starts at half the ring after the initial refill
            old           = 16'(esz / 2 + rcy_cnt);
            rcy_cnt       = rcy_cnt + 16'd1;
            res.ring_pos  = 8'(ring_slot(old, esz));
            res.ring_head = hid[7:0];
            res.avail_idx = old + 16'd1;
            res.notify    = 1'b1;
            res.queue_sel = 1'b0;
          end
        end
      end
      default: begin
        if (blen == 16'd0 || int'(blen) + HDR_BYTES > TX_LIMIT) begin
          res.status = ST_TX_REJECT;
        end else begin
          old           = tx_cnt;
          tx_cnt        = tx_cnt + 16'd1;
          res.status    = ST_TX_OK;
          res.xfer_len  = blen;
          res.data_addr = cfg_tx_base + 32'(HDR_BYTES);
          res.ring_pos  = 8'(ring_slot(old, int'(cfg_tx_size)));
          res.ring_head = 8'd0;
          res.avail_idx = old + 16'd1;
          res.notify    = 1'b1;
          res.queue_sel = 1'b1;
        end
      end
    endcase
    return 1'b1;
  endfunction

  task automatic match_field(input string fname, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      mism++;
      if (mism <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, want, got);
    end
  endtask

  initial begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      used_ids[i]  = '0;
      used_lens[i] = '0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cfg_link    = 1'b0;
      cfg_rx_size = 9'd256;
      cfg_tx_size = 9'd256;
      cfg_rx_base = '0;
      cfg_tx_base = '0;
      posted_cnt  = '0;
      taken_cnt   = '0;
      rcy_cnt     = '0;
      tx_cnt      = '0;
      due_results.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_results.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("%0t: result beat with nothing outstanding, status %0d",
                     $time, rsp_mon.status);
        end else begin
          due_head = due_results.pop_front();
          match_field("status",      32'(rsp_mon.status),    32'(due_head.status));
          match_field("payload_len", rsp_mon.payload_len,    due_head.payload_len);
          match_field("xfer_len",    32'(rsp_mon.xfer_len),  32'(due_head.xfer_len));
          match_field("data_addr",   rsp_mon.data_addr,      due_head.data_addr);
          match_field("ring_pos",    32'(rsp_mon.ring_pos),  32'(due_head.ring_pos));
          match_field("ring_head",   32'(rsp_mon.ring_head), 32'(due_head.ring_head));
          match_field("avail_idx",   32'(rsp_mon.avail_idx), 32'(due_head.avail_idx));
          match_field("notify",      32'(rsp_mon.notify),    32'(due_head.notify));
          match_field("queue_sel",   32'(rsp_mon.queue_sel), 32'(due_head.queue_sel));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (compute_ring_result(req_t'(req_mon.req_type), req_mon.used_id, req_mon.used_len,
                                req_mon.length, fresh))
          due_results.push_back(fresh);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_LINK_UP: cfg_link    = pwdata[0];
          REG_RX_SIZE: cfg_rx_size = pwdata[8:0];
          REG_TX_SIZE: cfg_tx_size = pwdata[8:0];
          REG_RX_BASE: cfg_rx_base = pwdata;
          REG_TX_BASE: cfg_tx_base = pwdata;
          default: ;
        endcase
      end
    end
    pending <= due_results.size();
    errors  <= mism;
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the virtqueue RX/TX ring engine. Runs a short
// directed sequence, then random phases over several register settings with
// random gaps on the request side and random stalls on the result side.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb;
  import vqring_pkg::*;

  localparam int QUEUE_DEPTH  = 256;
  localparam int BUFFER_BYTES = 2048;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 64;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int          errors;
  int          pending;
  bit          link_on;
  int unsigned rx_entries;
  int          backlog;
  int          src_quiet;
  int          sink_quiet;

  vqring_req_if req_ch ();
  vqring_rsp_if rsp_ch ();

  virtqueue_rx_tx_ring_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  vqring_ring_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) ring_chk (
    .clk    (clk),
    .rst    (rst),
    .req_mon(req_ch),
    .rsp_mon(rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .pready (pready),
    .pending(pending),
    .errors (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draw a random wait between beats, with occasional stretches of back-to-back beats.
  function automatic int pick_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  initial begin : result_sink
    int hold;
    rsp_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst)
        hold = 0;
      else if (rsp_ch.valid && rsp_ch.ready)
        hold = pick_gap(sink_quiet);
      else if (hold > 0)
        hold--;
      rsp_ch.ready <= !rst && hold == 0;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable && pready))
        idle = 0;
      else
        idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input req_t kind, input logic [15:0] id, input logic [31:0] ulen,
                           input logic [15:0] blen);
    int gap;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.used_id  <= id;
    req_ch.used_len <= ulen;
    req_ch.length   <= blen;
    do @(posedge clk); while (!req_ch.ready);
    // track unread completions so a queue resize never exposes stale entries
    if (link_on) begin
      if (kind == REQ_POST)
        backlog++;
      else if (kind == REQ_POLL && backlog > 0)
        backlog--;
    end
  endtask

  // Hold off new requests until every predicted result beat has arrived.
  task automatic quiesce(input int tail);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input bit link, input int unsigned rxs, input int unsigned txs,
                              input logic [31:0] rxb, input logic [31:0] txb);
    quiesce(DRAIN_CYCLES);
    if (rxs != rx_entries && backlog > 0) begin
      if (!link_on) begin
        write_reg(REG_LINK_UP, 32'd1);
        link_on = 1'b1;
      end
      while (backlog > 0)
        send_item(REQ_POLL, 16'($urandom), $urandom, 16'($urandom));
      quiesce(DRAIN_CYCLES);
    end
    write_reg(REG_LINK_UP, 32'(link));
    write_reg(REG_RX_SIZE, 32'(rxs));
    write_reg(REG_TX_SIZE, 32'(txs));
    write_reg(REG_RX_BASE, rxb);
    write_reg(REG_TX_BASE, txb);
    link_on    = link;
    rx_entries = rxs;
  endtask

  task automatic random_item(output bit counted);
    int unsigned pick;
    int unsigned sel;
    int unsigned sel_len;
    logic [15:0] id;
    logic [15:0] blen;
    logic [31:0] ulen;
    pick    = $urandom_range(0, 99);
    sel     = $urandom_range(0, 9);
    sel_len = $urandom_range(0, 9);
    id      = 16'($urandom);
    ulen    = $urandom;
    blen    = 16'($urandom);
    counted = 1'b1;
    if (pick < 38) begin
      if (sel < 6)
        id = 16'(2 * $urandom_range(0, (rx_entries - 1) / 2));
      else if (sel == 6)
        id = 16'd0;
      else if (sel == 7)
        id = 16'((rx_entries - 1) & ~32'd1);
      else if (sel == 9)
        id = ($urandom_range(0, 1) == 1) ? 16'(rx_entries) : 16'hFFFF;
      if (sel_len < 7)
        ulen = $urandom_range(11, 2058);
      else if (sel_len == 7)
        ulen = $urandom_range(0, 10);
      else if (sel_len == 9)
        ulen = 32'hFFFF_FFFF;
      send_item(REQ_POST, id, ulen, blen);
    end else if (pick < 72) begin
      if (sel >= 3)
        blen = 16'($urandom_range(0, 2100));
      send_item(REQ_POLL, id, ulen, blen);
    end else if (pick < 92) begin
      if (sel < 7)
        blen = 16'($urandom_range(1, 2038));
      else if (sel == 7)
        blen = 16'd0;
      else if (sel == 9)
        blen = 16'(2038 + $urandom_range(0, 1));
      send_item(REQ_SEND, id, ulen, blen);
    end else begin
      // unused request code: the block drops it
      counted = 1'b0;
      send_item(REQ_NONE, id, ulen, blen);
    end
  endtask

  task automatic run_phase(input bit link, input int unsigned rxs, input int unsigned txs,
                           input logic [31:0] rxb, input logic [31:0] txb, input int count);
    int  n;
    bit  paused;
    bit  counted;
    apply_config(link, rxs, txs, rxb, txb);
    n = 0;
    paused = 1'b0;
    while (n < count) begin
      if (n == count / 2 && !paused) begin
        quiesce(0);
        paused = 1'b1;
      end
      random_item(counted);
      if (counted) n++;
    end
  endtask

  initial begin : stimulus
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_NONE;
    req_ch.used_id  = '0;
    req_ch.used_len = '0;
    req_ch.length   = '0;
    link_on         = 1'b0;
    rx_entries      = 256;
    backlog         = 0;
    src_quiet       = 0;
    sink_quiet      = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // link down after reset: every request rejected
    send_item(REQ_POST, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(REQ_POLL, 16'h0000, 32'h0000_0000, 16'h0000);
    send_item(REQ_SEND, 16'h5A5A, 32'hA5A5_A5A5, 16'd100);
    send_item(REQ_NONE, 16'h1234, 32'h1234_5678, 16'd7);

    apply_config(1'b1, 256, 256, 32'hFFFF_F000, 32'hFFFF_FFF8);
    send_item(REQ_POLL, 16'h0000, 32'h0, 16'h1234);
    send_item(REQ_SEND, 16'h0000, 32'h0, 16'd0);
    send_item(REQ_SEND, 16'h0000, 32'h0, 16'd1);
    send_item(REQ_SEND, 16'h0000, 32'h0, 16'd2038);
    send_item(REQ_SEND, 16'h0000, 32'h0, 16'd2039);
    send_item(REQ_SEND, 16'h0000, 32'h0, 16'hFFFF);
    send_item(REQ_POST, 16'd0, 32'd11, 16'h0);
    send_item(REQ_POLL, 16'h0, 32'h0, 16'hFFFF);
    send_item(REQ_POST, 16'd254, 32'hFFFF_FFFF, 16'h0);
    send_item(REQ_POLL, 16'h0, 32'h0, 16'd0);
    send_item(REQ_POST, 16'd1, 32'd100, 16'h0);
    send_item(REQ_POLL, 16'h0, 32'h0, 16'd50);
    send_item(REQ_POST, 16'd256, 32'd100, 16'h0);
    send_item(REQ_POLL, 16'h0, 32'h0, 16'd50);
    send_item(REQ_POST, 16'hFFFF, 32'd0, 16'h0);
    send_item(REQ_POLL, 16'h0, 32'h0, 16'd50);
    send_item(REQ_POST, 16'd4, 32'd10, 16'h0);
    send_item(REQ_POLL, 16'h0, 32'h0, 16'd50);
    send_item(REQ_POST, 16'd8, 32'd2058, 16'h0);
    send_item(REQ_POLL, 16'h0, 32'h0, 16'd100);
    send_item(REQ_NONE, 16'h0, 32'h0, 16'h0);

    run_phase(1'b1, 2,   2,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 125);
    run_phase(1'b1, 255, 3,   $urandom,      $urandom,      125);
    run_phase(1'b0, 256, 256, $urandom,      $urandom,      25);
    run_phase(1'b1, 3,   256, 32'h0,         32'h0,         125);
    run_phase(1'b1, 256, 255, 32'hFFFF_F800, 32'h7FFF_FFFF, 125);
    run_phase(1'b1, $urandom_range(2, 256), $urandom_range(2, 256), $urandom, $urandom, 100);

    quiesce(DRAIN_CYCLES);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[virtqueue_rx_tx_ring_engine.f]
+incdir+hdl
hdl/vqring_pkg.sv
hdl/vqring_req_if.sv
hdl/vqring_rsp_if.sv
hdl/vqring_mod.sv
hdl/vqring_cfg.sv
hdl/vqring_core.sv
hdl/virtqueue_rx_tx_ring_engine.sv
dv/vqring_ring_checker.sv
dv/tb.sv
